/* rtl/skt_pkg.sv */
// Shared types, codes and constants for the session keepalive table.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    // Table size default and per-sweep result cap
    localparam int SLOTS_DEF   = 8;
    localparam int MAX_RESULTS = 8;

    // Field widths
    localparam int ID_W     = 16;
    localparam int TICK_W   = 32;
    localparam int SLOT_FW  = 6;
    localparam int COUNT_FW = 7;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [TICK_W-1:0] PING_INTERVAL_RST = 32'd10000;
    localparam logic [TICK_W-1:0] PONG_TIMEOUT_RST  = 32'd5000;

    typedef logic [ID_W-1:0]     id_t;
    typedef logic [TICK_W-1:0]   tick_t;
    typedef logic [SLOT_FW-1:0]  slot_t;
    typedef logic [COUNT_FW-1:0] count_t;

    typedef enum logic [2:0] {
        OP_CONNECT    = 3'd0,
        OP_DISCONNECT = 3'd1,
        OP_DATA       = 3'd2,
        OP_PONG       = 3'd3,
        OP_PING       = 3'd4,
        OP_SWEEP      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_PING    = 3'd1,
        ACT_CLOSE   = 3'd2,
        ACT_ECHO    = 3'd3,
        ACT_DELIVER = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PING_INTERVAL = 2'd0,
        REG_PONG_TIMEOUT  = 2'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_SCAN = 2'd1,
        FSM_EMIT = 2'd2
    } fsm_t;

    // Controller to datapath strobes
    typedef struct packed {
        logic start;      // latch the input beat, rewind the scan
        logic advance;    // step to the next slot
        logic do_update;  // apply this opcode's change to the current slot
        logic load_pend;  // capture the current slot's result
        logic push_pend;  // move the held result to the output, not final
        logic emit_last;  // move held (or default) result to the output, final
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_op_ok;   // opcode on the input beat is a defined one
        logic is_sweep;   // latched opcode is a sweep
        logic hit;        // current slot acts for the latched opcode
        logic at_end;     // current slot is the last one
        logic k_last;     // this sweep hit reaches the result cap
        logic pend_valid; // a result is held
        logic out_free;   // output register can take a beat this cycle
    } sts_t;

endpackage

`default_nettype wire

/* rtl/skt_ctrl.sv */
// Controller state machine: accepts items, walks the scan, sequences result beats.
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               cfg_ready,
    input  wire skt_pkg::sts_t sts,
    output skt_pkg::cmd_t      cmd
);

    skt_pkg::fsm_t state_reg;
    skt_pkg::fsm_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skt_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and strobes
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        cfg_ready     = 1'b0;
        case (state_reg)
            skt_pkg::FSM_IDLE: begin
                // no item in flight: take an item beat or a register write
                s_axis_tready = aresetn;
                cfg_ready     = aresetn;
                if (aresetn && s_axis_tvalid && sts.in_op_ok) begin
                    cmd.start  = 1'b1;
                    state_next = skt_pkg::FSM_SCAN;
                end
            end
            skt_pkg::FSM_SCAN: begin
                if (sts.hit) begin
                    // a sweep with a held result needs room to push it first
                    if (!(sts.is_sweep && sts.pend_valid && !sts.out_free)) begin
                        cmd.do_update = 1'b1;
                        cmd.load_pend = 1'b1;
                        cmd.push_pend = sts.is_sweep && sts.pend_valid;
                        if (!sts.is_sweep || sts.at_end || sts.k_last) begin
                            state_next = skt_pkg::FSM_EMIT;
                        end else begin
                            cmd.advance = 1'b1;
                        end
                    end
                end else if (sts.at_end) begin
                    state_next = skt_pkg::FSM_EMIT;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            skt_pkg::FSM_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_last = 1'b1;
                    state_next    = skt_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = skt_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/skt_dp.sv */
// Datapath: slot table, config registers, slot evaluation, held result and output register.
`timescale 1ns / 1ps
`default_nettype none

module skt_dp #(
    parameter int SLOTS = skt_pkg::SLOTS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input beat fields
    input  wire logic [2:0]                       in_op,
    input  wire skt_pkg::id_t                     in_id,
    input  wire skt_pkg::tick_t                   in_now,
    // config writes
    input  wire logic                             cfg_we,
    input  wire logic [skt_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire skt_pkg::tick_t                   cfg_data,
    // controller link
    input  wire skt_pkg::cmd_t                    cmd,
    output skt_pkg::sts_t                         sts,
    // result beat
    input  wire logic                             m_ready,
    output logic                                  m_valid,
    output skt_pkg::status_t                      m_status,
    output skt_pkg::action_t                      m_action,
    output skt_pkg::id_t                          m_target,
    output skt_pkg::slot_t                        m_slot,
    output skt_pkg::count_t                       m_count,
    output logic                                  m_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int K_W   = $clog2(skt_pkg::MAX_RESULTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [K_W-1:0]   K_CAP    = K_W'(skt_pkg::MAX_RESULTS - 1);

    // Config registers
    skt_pkg::tick_t ping_interval_reg;
    skt_pkg::tick_t pong_timeout_reg;

    // Latched item
    logic [2:0]     op_reg;
    skt_pkg::id_t   id_reg;
    skt_pkg::tick_t now_reg;

    // Scan state
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [K_W-1:0]   k_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Per-slot flags and table memories
    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] wait_reg;
    skt_pkg::id_t     conn_mem [SLOTS];
    skt_pkg::tick_t   seen_mem [SLOTS];
    skt_pkg::id_t     conn_rd_reg;
    skt_pkg::tick_t   seen_rd_reg;

    // Held result
    logic              pend_valid_reg;
    skt_pkg::status_t  pend_status_reg;
    skt_pkg::action_t  pend_action_reg;
    skt_pkg::id_t      pend_target_reg;
    skt_pkg::slot_t    pend_slot_reg;
    skt_pkg::count_t   pend_count_reg;

    // Output register
    logic              out_valid_reg;
    skt_pkg::status_t  out_status_reg;
    skt_pkg::action_t  out_action_reg;
    skt_pkg::id_t      out_target_reg;
    skt_pkg::slot_t    out_slot_reg;
    skt_pkg::count_t   out_count_reg;
    logic              out_last_reg;

    // Slot evaluation
    logic           is_connect;
    logic           is_lookup;
    logic           is_sweep;
    logic           cur_used;
    logic           cur_wait;
    skt_pkg::tick_t elapsed;
    logic           close_due;
    logic           ping_due;
    logic           match;
    logic           hit;
    logic           frees_slot;
    logic           seen_we;
    logic           out_free;
    skt_pkg::action_t cur_action;
    skt_pkg::id_t     cur_target;

    assign is_connect = (op_reg == skt_pkg::OP_CONNECT);
    assign is_lookup  = (op_reg == skt_pkg::OP_DISCONNECT) || (op_reg == skt_pkg::OP_DATA) ||
                        (op_reg == skt_pkg::OP_PONG) || (op_reg == skt_pkg::OP_PING);
    assign is_sweep   = (op_reg == skt_pkg::OP_SWEEP);

    assign cur_used  = used_reg[idx_reg];
    assign cur_wait  = wait_reg[idx_reg];
    assign elapsed   = now_reg - seen_rd_reg;
    assign close_due = cur_used && cur_wait && (elapsed >= pong_timeout_reg);
    assign ping_due  = cur_used && !cur_wait && (elapsed >= ping_interval_reg);
    assign match     = cur_used && (conn_rd_reg == id_reg);

    always_comb begin
        hit = 1'b0;
        if (is_connect) begin
            hit = !cur_used;
        end else if (is_lookup) begin
            hit = match;
        end else if (is_sweep) begin
            hit = close_due || ping_due;
        end
    end

    // Result fields for the current slot
    always_comb begin
        cur_action = skt_pkg::ACT_NONE;
        cur_target = id_reg;
        case (op_reg)
            skt_pkg::OP_DATA:  cur_action = skt_pkg::ACT_DELIVER;
            skt_pkg::OP_PING:  cur_action = skt_pkg::ACT_ECHO;
            skt_pkg::OP_SWEEP: begin
                cur_action = close_due ? skt_pkg::ACT_CLOSE : skt_pkg::ACT_PING;
                cur_target = conn_rd_reg;
            end
            default: cur_action = skt_pkg::ACT_NONE;
        endcase
    end

    // Occupancy after this update
    assign frees_slot = (op_reg == skt_pkg::OP_DISCONNECT) || (is_sweep && close_due);
    always_comb begin
        count_next = count_reg;
        if (cmd.do_update) begin
            if (is_connect) begin
                count_next = count_reg + CNT_W'(1);
            end else if (frees_slot) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    assign seen_we = cmd.do_update && (is_connect || ((op_reg != skt_pkg::OP_DISCONNECT) &&
                                                       is_lookup));

    // Scan index; the memory read follows the next index
    always_comb begin
        idx_next = idx_reg;
        if (cmd.start) begin
            idx_next = '0;
        end else if (cmd.advance) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ping_interval_reg <= skt_pkg::PING_INTERVAL_RST;
            pong_timeout_reg  <= skt_pkg::PONG_TIMEOUT_RST;
        end else if (cfg_we) begin
            if (cfg_addr == skt_pkg::REG_PING_INTERVAL) begin
                ping_interval_reg <= cfg_data;
            end else if (cfg_addr == skt_pkg::REG_PONG_TIMEOUT) begin
                pong_timeout_reg <= cfg_data;
            end
        end
    end

    // Latched item fields
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= in_op;
            id_reg  <= in_id;
            now_reg <= in_now;
        end
    end

    // Scan control, occupancy and slot flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            k_reg     <= '0;
            count_reg <= '0;
            used_reg  <= '0;
            wait_reg  <= '0;
        end else begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cmd.start) begin
                k_reg <= '0;
            end else if (cmd.do_update && is_sweep) begin
                k_reg <= k_reg + K_W'(1);
            end
            if (cmd.do_update) begin
                if (is_connect) begin
                    used_reg[idx_reg] <= 1'b1;
                    wait_reg[idx_reg] <= 1'b0;
                end else if (frees_slot) begin
                    used_reg[idx_reg] <= 1'b0;
                    wait_reg[idx_reg] <= 1'b0;
                end else if ((op_reg == skt_pkg::OP_DATA) || (op_reg == skt_pkg::OP_PONG)) begin
                    wait_reg[idx_reg] <= 1'b0;
                end else if (is_sweep) begin
                    wait_reg[idx_reg] <= 1'b1;
                end
            end
        end
    end

    // Table memories, registered read
    always_ff @(posedge aclk) begin
        if (cmd.do_update && is_connect) begin
            conn_mem[idx_reg] <= id_reg;
        end
        if (seen_we) begin
            seen_mem[idx_reg] <= now_reg;
        end
        conn_rd_reg <= conn_mem[idx_next];
        seen_rd_reg <= seen_mem[idx_next];
    end

    // Held result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.start) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.load_pend) begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pend) begin
            pend_status_reg <= skt_pkg::ST_OK;
            pend_action_reg <= cur_action;
            pend_target_reg <= cur_target;
            pend_slot_reg   <= skt_pkg::slot_t'(idx_reg);
            pend_count_reg  <= skt_pkg::count_t'(count_next);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push_pend || cmd.emit_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_pend || (cmd.emit_last && pend_valid_reg)) begin
            out_status_reg <= pend_status_reg;
            out_action_reg <= pend_action_reg;
            out_target_reg <= pend_target_reg;
            out_slot_reg   <= pend_slot_reg;
            out_count_reg  <= pend_count_reg;
            out_last_reg   <= cmd.emit_last;
        end else if (cmd.emit_last) begin
            // no slot acted: table full, unknown id, or a quiet sweep
            out_action_reg <= skt_pkg::ACT_NONE;
            out_slot_reg   <= '0;
            out_count_reg  <= skt_pkg::count_t'(count_reg);
            out_last_reg   <= 1'b1;
            if (is_connect) begin
                out_status_reg <= skt_pkg::ST_FULL;
                out_target_reg <= id_reg;
            end else if (is_lookup) begin
                out_status_reg <= skt_pkg::ST_UNKNOWN;
                out_target_reg <= id_reg;
            end else begin
                out_status_reg <= skt_pkg::ST_OK;
                out_target_reg <= '0;
            end
        end
    end

    // Status to the controller
    always_comb begin
        sts            = '0;
        sts.in_op_ok   = (in_op <= skt_pkg::OP_SWEEP);
        sts.is_sweep   = is_sweep;
        sts.hit        = hit;
        sts.at_end     = (idx_reg == LAST_IDX);
        sts.k_last     = (k_reg == K_CAP);
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_action = out_action_reg;
    assign m_target = out_target_reg;
    assign m_slot   = out_slot_reg;
    assign m_count  = out_count_reg;
    assign m_last   = out_last_reg;

endmodule

`default_nettype wire

/* rtl/session_keepalive_table.sv */
// Top level of the connection keepalive table: stream ports, config port, controller and datapath.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: opcode; tdata: conn_id, now
//  m_axis    out        tuser: status, action; tdata: target_id, slot, active_count; tlast
//  cfg       in         cfg_addr: register index; cfg_data: 32-bit value
//
// One item at a time. An item is accepted, then the scan visits the slots in order
// (connect and lookups stop at the first hit slot, a sweep walks all SLOTS or
// stops at its result cap), then the final beat is posted.
// Reset is synchronous, active low; it empties the table and reloads registers.
// Register writes are taken only between items; no port is ready during reset.
// A stalled m_axis holds a sweep when a result has nowhere to go, and holds the final beat.
`timescale 1ns / 1ps
`default_nettype none

module session_keepalive_table #(
    parameter int SLOTS = skt_pkg::SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [15:0] conn_id, [47:16] now
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] opcode
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] target_id, [21:16] slot,
                                             // [28:22] active_count, [31:29] zero
    output logic [4:0]       m_axis_tuser,   // [1:0] status, [4:2] action
    output logic             m_axis_tlast,
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [skt_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [31:0] cfg_data
);

    skt_pkg::cmd_t    cmd;
    skt_pkg::sts_t    sts;
    skt_pkg::status_t m_status;
    skt_pkg::action_t m_action;
    skt_pkg::id_t     m_target;
    skt_pkg::slot_t   m_slot;
    skt_pkg::count_t  m_count;

    skt_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cfg_ready     (cfg_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    skt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_op    (s_axis_tuser),
        .in_id    (s_axis_tdata[15:0]),
        .in_now   (s_axis_tdata[47:16]),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_ready  (m_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_status (m_status),
        .m_action (m_action),
        .m_target (m_target),
        .m_slot   (m_slot),
        .m_count  (m_count),
        .m_last   (m_axis_tlast)
    );

    // Beat packing
    assign m_axis_tdata = {3'b000, m_count, m_slot, m_target};
    assign m_axis_tuser = {m_action, m_status};

endmodule

`default_nettype wire
